// ----- src/stc_pkg.sv -----
// Shared constants, types and the month table for the seconds-to-date converter.
// No dependencies; imported by every module of the block.
package stc_pkg;

  // Input and day-count widths
  localparam int unsigned SEC_W = 32;
  localparam int unsigned DAY_W = 16;

  // Cycles from an accepted start to the result strobe
  localparam int unsigned LATENCY = 10;

  // Reciprocals for exact division by constants
  localparam logic [31:0] RECIP_60   = 32'h8888_8889;  // x / 60 = (x * R) >> 37
  localparam logic [31:0] RECIP_24   = 32'hAAAA_AAAB;  // x / 24 = (x * R) >> 36
  localparam logic [21:0] RECIP_1461 = 22'd2939744;    // floor(2^32 / 1461), may be one low

  // Four-year cycle: a leap year first, then three common years
  localparam logic [10:0] DAYS_PER_CYCLE = 11'd1461;
  localparam logic [10:0] YEAR1_START    = 11'd366;
  localparam logic [10:0] YEAR2_START    = 11'd731;
  localparam logic [10:0] YEAR3_START    = 11'd1096;

  // First day of each month in a common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // Time of day carried alongside the date walk
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } stc_hms_t;

  // First day of a month, shifted by one from March on in a leap year
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    base = MONTH_START[idx];
    return base + 9'((leap && (idx >= 4'd2)) ? 1 : 0);
  endfunction

endpackage

// ----- src/stc_clock_split.sv -----
// Splits a seconds count into whole days, hour, minute and second.
// Six register stages; uses stc_pkg for reciprocals and the time-of-day struct.
module stc_clock_split
  import stc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [SEC_W-1:0] in_seconds,
  output logic             out_valid,
  output logic [DAY_W-1:0] out_days,
  output stc_hms_t         out_hms
);

  logic [5:0]        v_r;
  logic [SEC_W-1:0]  t1_r;
  logic [63:0]       p1_r;
  logic [26:0]       q1_r, q1b_r;
  logic [5:0]        sec2_r, sec3_r, sec4_r, sec5_r, sec6_r;
  logic [63:0]       p2_r;
  logic [20:0]       q2_r, q2b_r;
  logic [5:0]        min4_r, min5_r, min6_r;
  logic [63:0]       p3_r;
  logic [DAY_W-1:0]  days_r;
  logic [4:0]        hour_r;

  logic [26:0]       q1_nxt;
  logic [31:0]       sec_full;
  logic [20:0]       q2_nxt;
  logic [26:0]       min_full;
  logic [DAY_W-1:0]  days_nxt;
  logic [20:0]       hour_full;

  // Quotient and remainder after each reciprocal product
  always_comb begin
    q1_nxt   = p1_r[63:37];
    sec_full = t1_r - (32'({q1_nxt, 6'b0}) - 32'({q1_nxt, 2'b0}));
    q2_nxt   = p2_r[57:37];
    min_full = q1b_r - (27'({q2_nxt, 6'b0}) - 27'({q2_nxt, 2'b0}));
    days_nxt = p3_r[51:36];
    hour_full = q2b_r - (21'({days_nxt, 4'b0}) + 21'({days_nxt, 3'b0}));
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    // stage 1: multiply by 1/60
    t1_r   <= in_seconds;
    p1_r   <= 64'(in_seconds) * 64'(RECIP_60);
    // stage 2: minutes count and seconds
    q1_r   <= q1_nxt;
    sec2_r <= sec_full[5:0];
    // stage 3: multiply by 1/60 again
    p2_r   <= 64'(q1_r) * 64'(RECIP_60);
    q1b_r  <= q1_r;
    sec3_r <= sec2_r;
    // stage 4: hours count and minutes
    q2_r   <= q2_nxt;
    min4_r <= min_full[5:0];
    sec4_r <= sec3_r;
    // stage 5: multiply by 1/24
    p3_r   <= 64'(q2_r) * 64'(RECIP_24);
    q2b_r  <= q2_r;
    min5_r <= min4_r;
    sec5_r <= sec4_r;
    // stage 6: days and hour
    days_r <= days_nxt;
    hour_r <= hour_full[4:0];
    min6_r <= min5_r;
    sec6_r <= sec5_r;
  end

  assign out_valid      = v_r[5];
  assign out_days       = days_r;
  assign out_hms.hour   = hour_r;
  assign out_hms.minute = min6_r;
  assign out_hms.second = sec6_r;

endmodule

// ----- src/stc_date_walk.sv -----
// Turns a day count into year offset, month and day of month.
// Four register stages; uses stc_pkg for the cycle constants and month table.
module stc_date_walk
  import stc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DAY_W-1:0] in_days,
  input  stc_hms_t         in_hms,
  output logic             out_valid,
  output logic [7:0]       out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day,
  output stc_hms_t         out_hms
);

  logic [3:0]       v_r;
  logic [37:0]      p4_r;
  logic [DAY_W-1:0] days1_r;
  logic [5:0]       cyc_r;
  logic [10:0]      rc_r;
  logic [7:0]       year3_r, year4_r;
  logic [8:0]       ry_r;
  logic             leap_r;
  logic [3:0]       month_r;
  logic [4:0]       day_r;
  stc_hms_t         hms1_r, hms2_r, hms3_r, hms4_r;

  logic [5:0]       cyc_est;
  logic [16:0]      r_est;
  logic [5:0]       cyc_nxt;
  logic [10:0]      rc_nxt;
  logic [1:0]       yin;
  logic [10:0]      ystart;
  logic [10:0]      ry_full;
  logic [10:0]      ge;
  logic [3:0]       midx;
  logic [8:0]       day_full;

  // Stage 2: cycle count with one correction step
  always_comb begin
    cyc_est = p4_r[37:32];
    r_est   = 17'(days1_r) - 17'(cyc_est) * 17'(DAYS_PER_CYCLE);
    if (r_est >= 17'(DAYS_PER_CYCLE)) begin
      cyc_nxt = cyc_est + 6'd1;
      rc_nxt  = 11'(r_est - 17'(DAYS_PER_CYCLE));
    end else begin
      cyc_nxt = cyc_est;
      rc_nxt  = r_est[10:0];
    end
  end

  // Stage 3: year within the cycle
  always_comb begin
    priority if (rc_r >= YEAR3_START) begin
      yin = 2'd3; ystart = YEAR3_START;
    end else if (rc_r >= YEAR2_START) begin
      yin = 2'd2; ystart = YEAR2_START;
    end else if (rc_r >= YEAR1_START) begin
      yin = 2'd1; ystart = YEAR1_START;
    end else begin
      yin = 2'd0; ystart = '0;
    end
    ry_full = rc_r - ystart;
  end

  // Stage 4: month by parallel compares against month starts
  always_comb begin
    for (int m = 1; m < 12; m++) begin
      ge[m-1] = (ry_r >= month_start(4'(m), leap_r));
    end
    midx     = 4'($countones(ge));
    day_full = ry_r - month_start(midx, leap_r) + 9'd1;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    p4_r    <= 38'(in_days) * 38'(RECIP_1461);
    days1_r <= in_days;
    hms1_r  <= in_hms;

    cyc_r   <= cyc_nxt;
    rc_r    <= rc_nxt;
    hms2_r  <= hms1_r;

    year3_r <= {cyc_r, yin};
    ry_r    <= ry_full[8:0];
    leap_r  <= (yin == 2'd0);
    hms3_r  <= hms2_r;

    year4_r <= year3_r;
    month_r <= midx + 4'd1;
    day_r   <= day_full[4:0];
    hms4_r  <= hms3_r;
  end

  assign out_valid = v_r[3];
  assign out_year  = year4_r;
  assign out_month = month_r;
  assign out_day   = day_r;
  assign out_hms   = hms4_r;

endmodule

// ----- src/seconds_to_calendar_date.sv -----
// Seconds since 2000-01-01 to calendar date and time of day.
// The out_valid strobe follows a start transfer through the clock-split stages, then the date-walk stages.
// Throughput: one conversion per cycle; busy is always low, so start may be high every cycle.
// The delay is set by the three reciprocal multiplies of the clock split and the date walk, each behind a register.
// Reset (synchronous, active low) clears the valid bits; items in flight are dropped.
// Depends on stc_pkg, stc_clock_split and stc_date_walk.
module seconds_to_calendar_date
  import stc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [SEC_W-1:0] in_seconds_count,
  output logic             out_valid,
  output logic [7:0]       out_year_offset,
  output logic [3:0]       out_month_number,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour_of_day,
  output logic [5:0]       out_minute_of_hour,
  output logic [5:0]       out_second_of_minute
);

  logic             split_valid;
  logic [DAY_W-1:0] split_days;
  stc_hms_t         split_hms;
  stc_hms_t         walk_hms;

  // The pipeline never stalls
  assign busy = 1'b0;

  stc_clock_split u_split (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start),
    .in_seconds (in_seconds_count),
    .out_valid  (split_valid),
    .out_days   (split_days),
    .out_hms    (split_hms)
  );

  stc_date_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_days   (split_days),
    .in_hms    (split_hms),
    .out_valid (out_valid),
    .out_year  (out_year_offset),
    .out_month (out_month_number),
    .out_day   (out_day_of_month),
    .out_hms   (walk_hms)
  );

  assign out_hour_of_day      = walk_hms.hour;
  assign out_minute_of_hour   = walk_hms.minute;
  assign out_second_of_minute = walk_hms.second;

  // Every accepted transfer yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after start");

  // No result without a matching start
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without start");

  // February stays within its length for the year
  a_february: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_month_number == 4'd2)) |->
      ((out_day_of_month <= 5'd28) ||
       ((out_day_of_month == 5'd29) && (out_year_offset[1:0] == 2'd0))))
    else $error("February day out of range");

  // Month stays in range, day is at least one and hour is at most 23
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_month_number >= 4'd1) && (out_month_number <= 4'd12) &&
                   (out_day_of_month >= 5'd1) && (out_hour_of_day <= 5'd23)))
    else $error("date field out of range");

endmodule
